@@ hw/rtl/cte_pkg.sv @@
package cte_pkg;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_NEXT = 3'd1,
        OP_INC  = 3'd2,
        OP_DEC  = 3'd3,
        OP_TICK = 3'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } t_in_item;

    typedef struct packed {
        logic [6:0] year_out;
        logic [3:0] month_out;
        logic [4:0] day_out;
        logic [4:0] hour_out;
        logic [5:0] minute_out;
        logic [5:0] second_out;
        logic [2:0] cursor_out;
        logic       blank_selected;
    } t_out_item;

    localparam logic [9:0] BLINK_PERIOD_RESET = 10'd500;

    localparam logic [2:0] CURSOR_YEAR   = 3'd0;
    localparam logic [2:0] CURSOR_MONTH  = 3'd1;
    localparam logic [2:0] CURSOR_DAY    = 3'd2;
    localparam logic [2:0] CURSOR_HOUR   = 3'd3;
    localparam logic [2:0] CURSOR_MINUTE = 3'd4;
    localparam logic [2:0] CURSOR_SECOND = 3'd5;

    localparam logic signed [8:0] YEAR_MAX   = 9'sd99;
    localparam logic signed [8:0] MONTH_MAX  = 9'sd12;
    localparam logic signed [8:0] HOUR_MAX   = 9'sd23;
    localparam logic signed [8:0] MINSEC_MAX = 9'sd59;
    localparam logic signed [8:0] ZERO_MIN   = 9'sd0;
    localparam logic signed [8:0] ONE_MIN    = 9'sd1;

endpackage

@@ hw/rtl/cte_in_stage.sv @@
module cte_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cte_pkg::t_in_item i_in_item,
    input  logic              i_take,
    output logic              o_valid,
    output cte_pkg::t_in_item o_item
);
    import cte_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
    end

endmodule

@@ hw/rtl/cte_core.sv @@
module cte_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  cte_pkg::t_in_item  i_item,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cte_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_wdata
);
    import cte_pkg::*;

    logic       r_out_valid;
    logic [6:0] r_year;
    logic [3:0] r_month;
    logic [4:0] r_day;
    logic [4:0] r_hour;
    logic [5:0] r_minute;
    logic [5:0] r_second;
    logic [2:0] r_cursor;
    logic       r_blink_phase;
    logic [9:0] r_tick_cnt;
    logic [9:0] r_blink_period;

    logic [6:0] n_year;
    logic [3:0] n_month;
    logic [4:0] n_day;
    logic [4:0] n_hour;
    logic [5:0] n_minute;
    logic [5:0] n_second;
    logic [2:0] n_cursor;
    logic       n_blink_phase;
    logic [9:0] n_tick_cnt;

    logic                step_up;
    logic                step_dn;
    logic [2:0]          sel;
    logic signed [8:0]   w_year;
    logic signed [8:0]   w_month;
    logic signed [8:0]   w_day;
    logic signed [8:0]   w_hour;
    logic signed [8:0]   w_minute;
    logic signed [8:0]   w_second;
    logic signed [8:0]   day_max;
    logic [10:0]         tick_inc;

    // field value plus the step, if this field is the selected one
    function automatic logic signed [8:0] stepped(input logic [6:0] val, input logic hit,
                                                  input logic up, input logic dn);
        logic signed [8:0] v;
        v = $signed({2'b00, val});
        if (hit && up) begin
            v = v + 9'sd1;
        end else if (hit && dn) begin
            v = v - 9'sd1;
        end
        return v;
    endfunction

    function automatic logic signed [8:0] wrap(input logic signed [8:0] v,
                                               input logic signed [8:0] lo,
                                               input logic signed [8:0] hi);
        logic signed [8:0] r;
        r = v;
        if (v > hi) begin
            r = lo;
        end else if (v < lo) begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic signed [8:0] month_len(input logic [3:0] month,
                                                    input logic [6:0] year);
        logic signed [8:0] len;
        unique case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 9'sd30;
            4'd2:                    len = (year[1:0] == 2'b00) ? 9'sd29 : 9'sd28;
            default:                 len = 9'sd31;
        endcase
        return len;
    endfunction

    assign o_take  = i_valid && (!r_out_valid || !i_out_stall);
    assign step_up = (i_item.op == OP_INC);
    assign step_dn = (i_item.op == OP_DEC);
    assign sel     = (r_cursor > CURSOR_SECOND) ? CURSOR_YEAR : r_cursor;

    assign w_year   = wrap(stepped(r_year, sel == CURSOR_YEAR, step_up, step_dn),
                           ZERO_MIN, YEAR_MAX);
    assign w_month  = wrap(stepped({3'b000, r_month}, sel == CURSOR_MONTH, step_up, step_dn),
                           ONE_MIN, MONTH_MAX);
    assign day_max  = month_len(w_month[3:0], w_year[6:0]);
    assign w_day    = wrap(stepped({2'b00, r_day}, sel == CURSOR_DAY, step_up, step_dn),
                           ONE_MIN, day_max);
    assign w_hour   = wrap(stepped({2'b00, r_hour}, sel == CURSOR_HOUR, step_up, step_dn),
                           ZERO_MIN, HOUR_MAX);
    assign w_minute = wrap(stepped({1'b0, r_minute}, sel == CURSOR_MINUTE, step_up, step_dn),
                           ZERO_MIN, MINSEC_MAX);
    assign w_second = wrap(stepped({1'b0, r_second}, sel == CURSOR_SECOND, step_up, step_dn),
                           ZERO_MIN, MINSEC_MAX);

    assign tick_inc = {1'b0, r_tick_cnt} + 11'd1;

    always_comb begin
        n_year        = r_year;
        n_month       = r_month;
        n_day         = r_day;
        n_hour        = r_hour;
        n_minute      = r_minute;
        n_second      = r_second;
        n_cursor      = r_cursor;
        n_blink_phase = r_blink_phase;
        n_tick_cnt    = r_tick_cnt;
        unique case (i_item.op)
            OP_LOAD: begin
                n_year   = i_item.load_year;
                n_month  = i_item.load_month;
                n_day    = i_item.load_day;
                n_hour   = i_item.load_hour;
                n_minute = i_item.load_minute;
                n_second = i_item.load_second;
            end
            OP_NEXT: begin
                n_cursor = (r_cursor >= CURSOR_SECOND) ? CURSOR_YEAR : r_cursor + 3'd1;
            end
            OP_INC, OP_DEC: begin
                n_year   = w_year[6:0];
                n_month  = w_month[3:0];
                n_day    = w_day[4:0];
                n_hour   = w_hour[4:0];
                n_minute = w_minute[5:0];
                n_second = w_second[5:0];
            end
            OP_TICK: begin
                if (tick_inc >= {1'b0, r_blink_period}) begin
                    n_tick_cnt    = 10'd0;
                    n_blink_phase = !r_blink_phase;
                end else begin
                    n_tick_cnt = tick_inc[9:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_year         <= 7'd0;
            r_month        <= 4'd1;
            r_day          <= 5'd1;
            r_hour         <= 5'd0;
            r_minute       <= 6'd0;
            r_second       <= 6'd0;
            r_cursor       <= CURSOR_YEAR;
            r_blink_phase  <= 1'b0;
            r_tick_cnt     <= 10'd0;
            r_blink_period <= BLINK_PERIOD_RESET;
        end else begin
            if (i_cfg_we) begin
                r_blink_period <= i_cfg_wdata;
            end
            if (o_take) begin
                r_out_valid   <= 1'b1;
                r_year        <= n_year;
                r_month       <= n_month;
                r_day         <= n_day;
                r_hour        <= n_hour;
                r_minute      <= n_minute;
                r_second      <= n_second;
                r_cursor      <= n_cursor;
                r_blink_phase <= n_blink_phase;
                r_tick_cnt    <= n_tick_cnt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state registers double as the result register
    assign o_out_valid               = r_out_valid;
    assign o_out_item.year_out       = r_year;
    assign o_out_item.month_out      = r_month;
    assign o_out_item.day_out        = r_day;
    assign o_out_item.hour_out       = r_hour;
    assign o_out_item.minute_out     = r_minute;
    assign o_out_item.second_out     = r_second;
    assign o_out_item.cursor_out     = r_cursor;
    assign o_out_item.blank_selected = r_blink_phase;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CURSOR_SECOND)
        else $error("cursor out of range");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (i_item.op == OP_INC || i_item.op == OP_DEC)) |=>
        (r_month >= 4'd1 && r_month <= 4'd12 && r_day >= 5'd1 && r_year <= 7'd99
         && r_hour <= 5'd23 && r_minute <= 6'd59 && r_second <= 6'd59))
        else $error("step left a field out of range");

    a_tick_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.op == OP_TICK && !i_cfg_we) |=>
        (r_tick_cnt == 10'd0 || r_tick_cnt < r_blink_period))
        else $error("tick count reached blink period");

    a_blink_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.op != OP_TICK) |=> ($stable(r_blink_phase) && $stable(r_tick_cnt)))
        else $error("blink state changed without a tick");

    a_no_update_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_take) |=> ($stable(r_cursor) && $stable(r_day) && $stable(r_month)))
        else $error("state changed with no item taken");

endmodule

@@ hw/rtl/calendar_time_field_editor.sv @@
// Date and time field editor. Holds year (0..99 when stepped; a load is stored
// as given), month, day, hour, minute and second, a field cursor and a blink
// phase. Every accepted item (load, next field, increment, decrement, tick, or
// an unused code that changes nothing) gives exactly one result item with the
// state after it. One item can be accepted every cycle while o_in_stall is low;
// each item passes through an input register and the state register, which is
// also the result register. o_in_stall rises only when both are full and the
// output is stalled. Reset gives year 0, month 1, day 1, time 00:00:00, cursor
// on year, blink period 500. i_cfg_we writes the blink period in tick items.
module calendar_time_field_editor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cte_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cte_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [9:0]         i_cfg_wdata
);
    import cte_pkg::*;

    logic     stage_valid;
    t_in_item stage_item;
    logic     take;

    cte_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_take     (take),
        .o_valid    (stage_valid),
        .o_item     (stage_item)
    );

    cte_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule

@@ sim/tb_calendar_time_field_editor.sv @@
module tb_calendar_time_field_editor;
    import cte_pkg::*;

    localparam t_op OP_SPARE5 = t_op'(3'd5);
    localparam t_op OP_SPARE7 = t_op'(3'd7);
    localparam int  IDLE_PCT  = 28;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;
    logic       cfg_we = 1'b0;
    logic [9:0] cfg_wdata = '0;

    // calendar model
    int          cal [6];
    int          cursor_pos;
    logic        blink_on;
    int          tick_cnt;
    int          period_now;

    t_out_item   pending_displays [$];
    t_out_item   want_item;
    t_row        script [$];
    bit          sender_lazy = 1'b1;
    bit          reader_lazy = 1'b1;

    int n_errors = 0;
    int n_sent = 0;
    int n_loads = 0;
    int n_steps = 0;
    int n_ticks = 0;
    int n_toggles = 0;
    int n_checked = 0;

    calendar_time_field_editor u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int days_in_month(int month, int year);
        case (month)
            4, 6, 9, 11: return 30;
            2:           return ((year & 3) == 0) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic void step_selected(bit up);
        int v [6];
        int sel;
        int lo;
        int hi;
        for (int i = 0; i < 6; i++) begin
            v[i] = cal[i] & 'h7F;
        end
        sel = (cursor_pos < 6) ? cursor_pos : 0;
        v[sel] = v[sel] + (up ? 1 : -1);
        for (int i = 0; i < 6; i++) begin
            lo = (i == 1 || i == 2) ? int'(ONE_MIN) : int'(ZERO_MIN);
            case (i)
                0:       hi = int'(YEAR_MAX);
                1:       hi = int'(MONTH_MAX);
                2:       hi = days_in_month(v[1], v[0]);
                3:       hi = int'(HOUR_MAX);
                default: hi = int'(MINSEC_MAX);
            endcase
            if (v[i] > hi) begin
                v[i] = lo;
            end else if (v[i] < lo) begin
                v[i] = hi;
            end
            cal[i] = v[i] & 'h7F;
        end
    endfunction

    function automatic void advance_calendar(t_in_item it);
        case (it.op)
            OP_LOAD: begin
                cal[0] = int'(it.load_year);
                cal[1] = int'(it.load_month);
                cal[2] = int'(it.load_day);
                cal[3] = int'(it.load_hour);
                cal[4] = int'(it.load_minute);
                cal[5] = int'(it.load_second);
            end
            OP_NEXT: cursor_pos = (cursor_pos >= 5) ? 0 : cursor_pos + 1;
            OP_INC:  step_selected(1'b1);
            OP_DEC:  step_selected(1'b0);
            OP_TICK: begin
                tick_cnt = (tick_cnt + 1) & 'h7FF;
                if (tick_cnt >= period_now) begin
                    tick_cnt = 0;
                    blink_on = ~blink_on;
                    n_toggles++;
                end
                tick_cnt = tick_cnt & 'h3FF;
            end
            default: ;
        endcase
    endfunction

    function automatic t_out_item shown(int y, int mo, int d, int h, int mi, int s,
                                        logic [2:0] cur, logic blank);
        t_out_item e;
        e.year_out       = 7'(y);
        e.month_out      = 4'(mo);
        e.day_out        = 5'(d);
        e.hour_out       = 5'(h);
        e.minute_out     = 6'(mi);
        e.second_out     = 6'(s);
        e.cursor_out     = cur;
        e.blank_selected = blank;
        return e;
    endfunction

    function automatic t_out_item current_display();
        return shown(cal[0], cal[1], cal[2], cal[3], cal[4], cal[5], 3'(cursor_pos),
                     blink_on);
    endfunction

    function automatic t_row mk_row(t_op op, int y, int mo, int d, int h, int mi, int s,
                                    bit typed, t_out_item want);
        t_row r;
        r.item.op          = op;
        r.item.load_year   = 7'(y);
        r.item.load_month  = 4'(mo);
        r.item.load_day    = 5'(d);
        r.item.load_hour   = 5'(h);
        r.item.load_minute = 6'(mi);
        r.item.load_second = 6'(s);
        r.typed            = typed;
        r.want             = want;
        return r;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        pick = $urandom_range(99);
        it.load_year   = 7'($urandom);
        it.load_month  = 4'($urandom);
        it.load_day    = 5'($urandom);
        it.load_hour   = 5'($urandom);
        it.load_minute = 6'($urandom);
        it.load_second = 6'($urandom);
        if (pick < 15) begin
            it.op = OP_LOAD;
            if ($urandom_range(3) != 0) begin
                it.load_year   = 7'($urandom_range(99));
                it.load_month  = 4'($urandom_range(12, 1));
                it.load_day    = 5'($urandom_range(31, 1));
                it.load_hour   = 5'($urandom_range(23));
                it.load_minute = 6'($urandom_range(59));
                it.load_second = 6'($urandom_range(59));
            end
        end else if (pick < 35) begin
            it.op = OP_NEXT;
        end else if (pick < 60) begin
            it.op = OP_INC;
        end else if (pick < 85) begin
            it.op = OP_DEC;
        end else if (pick < 97) begin
            it.op = OP_TICK;
        end else begin
            it.op = t_op'(3'($urandom_range(7, 5)));
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        while (sender_lazy && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        advance_calendar(it);
        pending_displays.push_back(typed ? want : current_display());
        n_sent++;
        if (it.op == OP_LOAD) n_loads++;
        if (it.op == OP_INC || it.op == OP_DEC) n_steps++;
        if (it.op == OP_TICK) n_ticks++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_displays.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_period(int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= 10'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        period_now = value & 'h3FF;
    endtask

    function automatic void check_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (pending_displays.size() == 0) begin
                    $display("%0t: unexpected item, expected none got %h", $time, out_item);
                    n_errors++;
                end else begin
                    want_item = pending_displays.pop_front();
                    check_field("year", 7'(want_item.year_out), 7'(out_item.year_out));
                    check_field("month", 7'(want_item.month_out), 7'(out_item.month_out));
                    check_field("day", 7'(want_item.day_out), 7'(out_item.day_out));
                    check_field("hour", 7'(want_item.hour_out), 7'(out_item.hour_out));
                    check_field("minute", 7'(want_item.minute_out),
                                7'(out_item.minute_out));
                    check_field("second", 7'(want_item.second_out),
                                7'(out_item.second_out));
                    check_field("cursor", 7'(want_item.cursor_out),
                                7'(out_item.cursor_out));
                    check_field("blank", 7'(want_item.blank_selected),
                                7'(out_item.blank_selected));
                    n_checked++;
                end
            end
            out_stall <= reader_lazy && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin
        #2000000;
        $display("calendar_time_field_editor verification failed");
        $finish;
    end

    initial begin
        int wait_cnt;
        int period;
        t_row r;
        for (int i = 0; i < 6; i++) begin
            cal[i] = 0;
        end
        cal[1]     = 1;
        cal[2]     = 1;
        cursor_pos = 0;
        blink_on   = 1'b0;
        tick_cnt   = 0;
        period_now = int'(BLINK_PERIOD_RESET);

        script.push_back(mk_row(OP_SPARE5, 0, 0, 0, 0, 0, 0, 1'b1,
                                shown(0, 1, 1, 0, 0, 0, CURSOR_YEAR, 1'b0)));
        script.push_back(mk_row(OP_SPARE7, 127, 15, 31, 31, 63, 63, 1'b1,
                                shown(0, 1, 1, 0, 0, 0, CURSOR_YEAR, 1'b0)));
        script.push_back(mk_row(OP_DEC, 0, 0, 0, 0, 0, 0, 1'b1,
                                shown(99, 1, 1, 0, 0, 0, CURSOR_YEAR, 1'b0)));
        script.push_back(mk_row(OP_INC, 0, 0, 0, 0, 0, 0, 1'b1,
                                shown(0, 1, 1, 0, 0, 0, CURSOR_YEAR, 1'b0)));
        script.push_back(mk_row(OP_LOAD, 99, 12, 31, 23, 59, 59, 1'b1,
                                shown(99, 12, 31, 23, 59, 59, CURSOR_YEAR, 1'b0)));
        script.push_back(mk_row(OP_LOAD, 127, 15, 31, 31, 63, 63, 1'b1,
                                shown(127, 15, 31, 31, 63, 63, CURSOR_YEAR, 1'b0)));
        script.push_back(mk_row(OP_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_LOAD, 0, 0, 0, 0, 0, 0, 1'b1,
                                shown(0, 0, 0, 0, 0, 0, CURSOR_YEAR, 1'b0)));
        script.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0, 1'b1,
                                shown(0, 0, 0, 0, 0, 0, CURSOR_MONTH, 1'b0)));
        script.push_back(mk_row(OP_DEC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_LOAD, 3, 2, 29, 12, 30, 30, 1'b1,
                                shown(3, 2, 29, 12, 30, 30, CURSOR_DAY, 1'b0)));
        script.push_back(mk_row(OP_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_DEC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_LOAD, 4, 2, 29, 12, 30, 30, 1'b1,
                                shown(4, 2, 29, 12, 30, 30, CURSOR_DAY, 1'b0)));
        script.push_back(mk_row(OP_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_LOAD, 0, 4, 30, 0, 0, 0, 1'b1,
                                shown(0, 4, 30, 0, 0, 0, CURSOR_HOUR, 1'b0)));
        script.push_back(mk_row(OP_DEC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_DEC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_INC, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_NEXT, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        script.push_back(mk_row(OP_TICK, 0, 0, 0, 0, 0, 0, 1'b0, '0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < script.size(); k++) begin
            r = script[k];
            send_item(r.item, r.typed, r.want);
        end

        // period extremes, then a lowered period while the count is high
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0:       period = 1;
                1:       period = 0;
                2:       period = 1023;
                3:       period = $urandom_range(9, 2);
                4:       period = $urandom_range(40, 10);
                default: period = $urandom_range(6, 2);
            endcase
            write_period(period);
            sender_lazy = (ph != 4);
            reader_lazy = (ph != 4);
            repeat (240) send_item(random_item(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        wait_cnt = 0;
        while (pending_displays.size() != 0 && wait_cnt < 2000) begin
            @(posedge clk);
            wait_cnt++;
        end
        if (pending_displays.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, pending_displays.size());
            n_errors++;
        end
        repeat (10) @(posedge clk);

        $display("sent %0d items: %0d loads, %0d steps, %0d ticks with %0d blink toggles",
                 n_sent, n_loads, n_steps, n_ticks, n_toggles);
        $display("checked %0d results over blink periods 500, 1, 0, 1023 and small ones",
                 n_checked);
        if (n_errors == 0) begin
            $display("calendar_time_field_editor verification clean");
        end else begin
            $display("calendar_time_field_editor verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/cte_pkg.sv
hw/rtl/cte_in_stage.sv
hw/rtl/cte_core.sv
hw/rtl/calendar_time_field_editor.sv
sim/tb_calendar_time_field_editor.sv
